// File: design/assert_macros.svh
// Assertion macros shared by the box blur RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define RBB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RBB_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed");
`else
`define RBB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RBB_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: design/rbb_pkg.sv
// Package for the RGB 3x3 box blur: register codes, field widths, lane control.
// No dependencies.
package rbb_pkg;

	localparam int CHAN_COUNT   = 3;
	localparam int WIDTH_BITS   = 11;
	localparam int HEIGHT_BITS  = 13;
	localparam int ROW_BITS     = 12;
	localparam int CFG_DATA_BITS = HEIGHT_BITS;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [HEIGHT_BITS-1:0] MAX_HEIGHT   = 13'd4096;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} lane_ctrl_t;

endpackage

// File: design/rbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/rbb_lane.sv
// One channel lane of the box blur: registered 3x3 sum, then divide by nine.
// Depends on rbb_pkg for the lane control struct.
module rbb_lane
	import rbb_pkg::*;
#(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                    clk,
	input  lane_ctrl_t              ctrl,
	input  logic [CHANNEL_BITS-1:0] samp [9],
	output logic [CHANNEL_BITS-1:0] q_s3
);

	localparam int CB  = CHANNEL_BITS;
	localparam int SB  = CB + 4;
	localparam int K   = SB + 4;
	localparam int PB  = SB + K + 1;
	localparam logic [K:0] RECIP = (K+1)'(((1 << K) + 8) / 9);

	logic [CB+1:0] col_sum [3];
	logic [SB-1:0] sum;
	logic [SB-1:0] sum_s2;
	logic [PB-1:0] prod;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			col_sum[i] = (CB+2)'(samp[3*i]) + (CB+2)'(samp[3*i+1]) + (CB+2)'(samp[3*i+2]);
		end
		sum = SB'(col_sum[0]) + SB'(col_sum[1]) + SB'(col_sum[2]);
	end

	// floor(x / 9) by reciprocal multiply, exact for every SB-bit sum
	assign prod = PB'(sum_s2) * PB'(RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			sum_s2 <= sum;
		end
		if (ctrl.en_s3) begin
			q_s3 <= CB'(prod >> K);
		end
	end

endmodule

// File: design/rgb_box_blur_3x3_top.sv
// Top level of the RGB 3x3 box blur: counters, line stores, window, lanes, output.
// Depends on rbb_pkg, rbb_ram, rbb_lane and assert_macros.svh.
//
// Usage:
//   Pixels enter in raster order on the s_ channel, one per transfer; s_tdata holds
//   red, green, blue from the lowest bit up. For every pixel at row >= 2 and
//   column >= 2 the mean of the 3x3 window centred one row and one column back
//   leaves on the m_ channel; border positions give no transfer. m_tlast marks
//   the last interior pixel of the frame.
//   Each result passes the stage registers s1, s2 and s3 in turn before it leaves.
//   Throughput: one pixel per cycle unless the receiver stalls, set by the single
//   read and single write port of each line store RAM, which are used once per pixel.
//   A stalled receiver holds the output register; the upstream stages keep
//   accepting while a bubble remains ahead of them.
//   Reset sets width 640 and height 480 and starts a new frame. Line stores are
//   not cleared. A write on the cfg_ port applies at once and restarts the frame;
//   write only while the block is idle.
`include "assert_macros.svh"

module rgb_box_blur_3x3_top
	import rbb_pkg::*;
#(
	parameter int MAX_WIDTH    = 1024,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_wr_en,
	input  cfg_reg_t                                     cfg_addr,
	input  logic [CFG_DATA_BITS-1:0]                     cfg_wr_data,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// red_in, green_in, blue_in
	input  logic [((CHAN_COUNT*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// red_out, green_out, blue_out
	output logic [((CHAN_COUNT*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
	output logic                                         m_tlast
);

	localparam int CB = CHANNEL_BITS;
	localparam int PW = CHAN_COUNT * CB;
	localparam int TW = ((PW + 7) / 8) * 8;
	localparam int CW = $clog2(MAX_WIDTH);

	logic [WIDTH_BITS-1:0]  image_width_q;
	logic [HEIGHT_BITS-1:0] image_height_q;
	logic [CW-1:0]          col_q;
	logic [ROW_BITS-1:0]    row_q;
	logic [CW-1:0]          col_last;
	logic [ROW_BITS-1:0]    row_last;

	logic en1, en2, en3, accept, adv_s1;
	logic v_s1, v_s2, v_s3;
	logic res_s1, last_s1, last_s2, last_s3;
	logic [CW-1:0] col_s1;
	logic [PW-1:0] px_s1;
	logic [PW-1:0] a_rd, b_rd;
	logic [CHAN_COUNT-1:0][CB-1:0] cur [3];
	logic [CHAN_COUNT-1:0][CB-1:0] win_q [3][2];
	logic [CHAN_COUNT-1:0][CB-1:0] q_s3;
	lane_ctrl_t lane_ctrl;

	always_comb begin
		if (image_width_q < WIDTH_BITS'(3)) begin
			col_last = CW'(2);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			col_last = CW'(MAX_WIDTH - 1);
		end else begin
			col_last = CW'(image_width_q - WIDTH_BITS'(1));
		end
		if (image_height_q < HEIGHT_BITS'(3)) begin
			row_last = ROW_BITS'(2);
		end else if (image_height_q > MAX_HEIGHT) begin
			row_last = '1;
		end else begin
			row_last = ROW_BITS'(image_height_q - HEIGHT_BITS'(1));
		end
	end

	assign en3      = !v_s3 || m_tready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign accept   = s_tvalid && en1;
	assign adv_s1   = v_s1 && en2;

	assign lane_ctrl.en_s2 = en2;
	assign lane_ctrl.en_s3 = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_wr_data[WIDTH_BITS-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wr_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == col_last) begin
				col_q <= '0;
				row_q <= (row_q == row_last) ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= s_tvalid;
			end
			if (en2) begin
				v_s2 <= v_s1 && res_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1   <= s_tdata[PW-1:0];
			col_s1  <= col_q;
			res_s1  <= (row_q >= ROW_BITS'(2)) && (col_q >= CW'(2));
			last_s1 <= (row_q == row_last) && (col_q == col_last);
		end
		if (en2) begin
			last_s2 <= last_s1;
		end
		if (en3) begin
			last_s3 <= last_s2;
		end
		if (adv_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= cur[r];
			end
		end
	end

	rbb_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_a (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (px_s1),
		.rd_en   (en1),
		.rd_addr (col_q),
		.rd_data (a_rd)
	);

	rbb_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_b (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (a_rd),
		.rd_en   (en1),
		.rd_addr (col_q),
		.rd_data (b_rd)
	);

	assign cur[0] = b_rd;
	assign cur[1] = a_rd;
	assign cur[2] = px_s1;

	for (genvar k = 0; k < CHAN_COUNT; k++) begin : g_lane
		logic [CB-1:0] samp [9];

		always_comb begin
			for (int r = 0; r < 3; r++) begin
				samp[3*r]   = win_q[r][0][k];
				samp[3*r+1] = win_q[r][1][k];
				samp[3*r+2] = cur[r][k];
			end
		end

		rbb_lane #(.CHANNEL_BITS(CB)) u_lane (
			.clk  (clk),
			.ctrl (lane_ctrl),
			.samp (samp),
			.q_s3 (q_s3[k])
		);
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = TW'(q_s3);
	assign m_tlast  = last_s3;

	`RBB_ASSERT_NEVER(a_col_bound, clk, arst_n, col_q > col_last)
	`RBB_ASSERT_NEVER(a_row_bound, clk, arst_n, row_q > row_last)
	`RBB_ASSERT_IMPL(a_last_is_result, clk, arst_n, v_s1 && last_s1, res_s1)
	`RBB_ASSERT_IMPL(a_drop_border, clk, arst_n, adv_s1 && !res_s1, ##1 !v_s2)

endmodule

// File: test/tb.sv
// Testbench for rgb_box_blur_3x3_top: random and directed RGB frames against a 3x3 mean predictor.
// Checks every output transfer and stalls both stream sides at random.
// Depends on rbb_pkg and the rgb_box_blur_3x3_top RTL.
`timescale 1ns / 1ps

module tb
	import rbb_pkg::*;
();

	localparam int MAX_W        = 1024;
	localparam int MAX_H        = 4096;
	localparam int DRAIN_CYCLES = 10;
	localparam int QUIET_LIMIT  = 4000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} blur_px_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	cfg_reg_t                 cfg_addr = REG_IMAGE_WIDTH;
	logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [23:0]              s_tdata = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [23:0]              m_tdata;
	logic                     m_tlast;

	logic hold_off = 1'b0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   mismatches = 0;
	int   quiet_cycles = 0;

	// predictor state
	logic [23:0] row_above [0:MAX_W-1];
	logic [23:0] two_rows_above [0:MAX_W-1];
	logic [23:0] window [0:5];
	int          col_pos;
	int          row_pos;
	logic [10:0] width_reg;
	logic [12:0] height_reg;
	blur_px_t    blur_expected [$];

	rgb_box_blur_3x3_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function int used_width();
		int w;
		w = int'(width_reg);
		if (w < 3) w = 3;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function int used_height();
		int h;
		h = int'(height_reg);
		if (h < 3) h = 3;
		if (h > MAX_H) h = MAX_H;
		return h;
	endfunction

	function void blur_reset();
		for (int i = 0; i < 6; i++) window[i] = '0;
		col_pos = 0;
		row_pos = 0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
	endfunction

	function void predict_blur(logic [23:0] px);
		int          w, h, c, r, sum;
		logic [23:0] top, mid, mean;
		blur_px_t    res;
		w = used_width();
		h = used_height();
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		top = two_rows_above[c];
		mid = row_above[c];
		two_rows_above[c] = mid;
		row_above[c] = px;
		if (r >= 2 && c >= 2) begin
			for (int k = 0; k < 3; k++) begin
				sum = window[0][8*k +: 8] + window[1][8*k +: 8] + top[8*k +: 8]
					+ window[2][8*k +: 8] + window[3][8*k +: 8] + mid[8*k +: 8]
					+ window[4][8*k +: 8] + window[5][8*k +: 8] + px[8*k +: 8];
				mean[8*k +: 8] = 8'(sum / 9);
			end
			res.red = mean[7:0];
			res.green = mean[15:8];
			res.blue = mean[23:16];
			res.last = (r == h - 1) && (c == w - 1);
			blur_expected.push_back(res);
		end
		window[0] = window[1];
		window[1] = top;
		window[2] = window[3];
		window[3] = mid;
		window[4] = window[5];
		window[5] = px;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endfunction

	function logic [23:0] rand_px();
		case ($urandom_range(7))
			0: return 24'h000000;
			1: return 24'hffffff;
			default: return 24'($urandom);
		endcase
	endfunction

	task report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task send_pixel(logic [23:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		predict_blur(px);
	endtask

	task wait_drained();
		s_tvalid <= 1'b0;
		while (blur_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = val[10:0];
		else
			height_reg = val;
		col_pos = 0;
		row_pos = 0;
	endtask

	task test_reset_size();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (2 * used_width() + 8) send_pixel(rand_px());
	endtask

	task test_directed_frames();
		logic [7:0] r, g, b;
		set_reg(REG_IMAGE_WIDTH, '0);
		set_reg(REG_IMAGE_HEIGHT, '0);
		repeat (9) send_pixel(24'hffffff);
		// second frame follows without a write: counters wrap
		for (int i = 0; i < 9; i++) begin
			r = (i == 4) ? 8'd8 : 8'd0;
			g = (i == 0) ? 8'd246 : 8'd255;
			b = 8'(i + (i == 8));
			send_pixel({b, g, r});
		end
		repeat (9) send_pixel(24'h000000);
	endtask

	task test_size_extremes();
		set_reg(REG_IMAGE_WIDTH, '1);
		set_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(3));
		repeat (40) send_pixel(rand_px());
		set_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(3));
		set_reg(REG_IMAGE_HEIGHT, '1);
		repeat (60) send_pixel(rand_px());
		set_reg(REG_IMAGE_HEIGHT, 13'd4096);
		set_reg(REG_IMAGE_WIDTH, 13'h0805);
		repeat (40) send_pixel(rand_px());
	endtask

	task test_backpressure();
		set_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(8));
		set_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(12));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off <= 1'b0;
			end
			repeat (96) send_pixel(rand_px());
		join
	endtask

	task test_random_frames(int idle_pct, int stall_pct, int n_items);
		int sent, w, h, n;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(9))
				0: w = $urandom_range(2);
				1: w = $urandom_range(13, 30);
				default: w = $urandom_range(3, 10);
			endcase
			h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 5);
			set_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
			set_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
			n = $urandom_range(1, 2) * used_width() * used_height();
			// truncate some frames so the next write restarts mid-frame
			if ($urandom_range(5) == 0) n = $urandom_range(1, n - 1);
			repeat (n) send_pixel(rand_px());
			sent += n;
		end
	endtask

	always @(posedge clk) begin : receive_check
		blur_px_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (blur_expected.size() == 0) begin
				report_mismatch("unexpected transfer", int'(m_tdata), 0);
			end else begin
				want = blur_expected.pop_front();
				if (m_tdata[7:0] !== want.red)
					report_mismatch("red", int'(m_tdata[7:0]), int'(want.red));
				if (m_tdata[15:8] !== want.green)
					report_mismatch("green", int'(m_tdata[15:8]), int'(want.green));
				if (m_tdata[23:16] !== want.blue)
					report_mismatch("blue", int'(m_tdata[23:16]), int'(want.blue));
				if (m_tlast !== want.last)
					report_mismatch("tlast", int'(m_tlast), int'(want.last));
			end
		end
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, no transfer for %0d cycles", $realtime, QUIET_LIMIT);
			$display("rgb_box_blur_3x3_top test failed");
			$finish;
		end
	end

	initial begin
		blur_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_directed_frames();
		test_size_extremes();
		test_backpressure();
		test_random_frames(0, 0, 80);
		test_random_frames(53, 0, 80);
		test_random_frames(0, 53, 80);
		test_random_frames(14, 14, 80);
		wait_drained();
		if (mismatches == 0)
			$display("rgb_box_blur_3x3_top test passed");
		else
			$display("rgb_box_blur_3x3_top test failed");
		$finish;
	end

endmodule
